>>> rtl/mrfp_pkg.sv
// ----------------------------------------------------------------------------
// mrfp_pkg
// shared types and constants of the motor reply frame parser
// ----------------------------------------------------------------------------
package mrfp_pkg;

	localparam logic [7:0] HDR_BYTE    = 8'hAA;
	localparam logic [7:0] END_BYTE    = 8'h3B;
	localparam int         STORE_DEPTH = 16;
	localparam int         PTR_W       = $clog2(STORE_DEPTH);

	// frame positions of the latched header fields
	localparam int POS_CMD  = 3;
	localparam int POS_SEL  = 4;
	localparam int POS_UNIT = 5;

	// monitor select and unit that allow a reply
	localparam logic [7:0] SEL_OK  = 8'd0;
	localparam logic [7:0] UNIT_OK = 8'd3;

	// payload runs within the frame store
	localparam logic [PTR_W-1:0] PV_FIRST = PTR_W'(4);
	localparam logic [PTR_W-1:0] PV_LAST  = PTR_W'(15);
	localparam logic [PTR_W-1:0] FW_FIRST = PTR_W'(6);
	localparam logic [PTR_W-1:0] FW_LAST  = PTR_W'(11);

	// payload kinds
	localparam logic KIND_POSVEL = 1'b0;
	localparam logic KIND_FWVER  = 1'b1;

	// configuration register indexes
	localparam logic REG_POSVEL = 1'b0;
	localparam logic REG_FWVER  = 1'b1;

	localparam logic [7:0] POSVEL_RST = 8'd12;
	localparam logic [7:0] FWVER_RST  = 8'd1;

	typedef struct packed {
		logic take;   // input transaction this cycle
		logic load;   // move next payload byte to the output register
		logic finish; // burst done, clear the frame store
	} ctrl_cmd_t;

	typedef struct packed {
		logic emit_req; // current input byte closes a frame that replies
		logic last_pos; // emit pointer sits on the final byte of the run
	} dp_status_t;

endpackage

>>> rtl/mrfp_datapath.sv
// ----------------------------------------------------------------------------
// mrfp_datapath
// header hunt, frame store, field latches and payload output register
// ----------------------------------------------------------------------------
module mrfp_datapath #(
	parameter int FRAME_MAX = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic [7:0]         rx_byte,
	input  mrfp_pkg::ctrl_cmd_t cmd,
	output mrfp_pkg::dp_status_t status,
	output logic [7:0]         out_byte,
	output logic               payload_kind,
	output logic               last
);
	import mrfp_pkg::*;

	localparam int IDX_W = $clog2(FRAME_MAX + 1);

	logic [7:0]             posvel_q;
	logic [7:0]             fwver_q;
	logic [1:0]             hdr_cnt_q;
	logic                   in_frame_q;
	logic [IDX_W-1:0]       idx_q;
	logic [STORE_DEPTH-1:0] valid_q;
	logic [7:0]             store_q [STORE_DEPTH];
	logic [7:0]             cmd_q;
	logic [7:0]             sel_q;
	logic [7:0]             unit_q;
	logic [PTR_W-1:0]       ptr_q;
	logic                   kind_q;

	logic [7:0] cmd_n;
	logic [7:0] sel_n;
	logic [7:0] unit_n;
	logic       is_hdr;
	logic       is_end;
	logic       put;
	logic       in_store;
	logic       not_full;
	logic       closing;
	logic       sel_ok;
	logic       pv_hit;
	logic       fw_hit;
	logic [7:0] rd_byte;

	assign is_hdr   = (rx_byte == HDR_BYTE);
	assign is_end   = (rx_byte == END_BYTE);
	assign not_full = (idx_q != IDX_W'(FRAME_MAX));
	assign in_store = (idx_q < IDX_W'(STORE_DEPTH));
	assign put      = cmd.take && (in_frame_q || is_hdr) && not_full;
	assign closing  = cmd.take && in_frame_q && is_end;

	// latch values as they stand after this byte
	assign cmd_n  = (in_frame_q && idx_q == IDX_W'(POS_CMD))  ? rx_byte : cmd_q;
	assign sel_n  = (in_frame_q && idx_q == IDX_W'(POS_SEL))  ? rx_byte : sel_q;
	assign unit_n = (in_frame_q && idx_q == IDX_W'(POS_UNIT)) ? rx_byte : unit_q;

	assign sel_ok = (sel_n == SEL_OK) && (unit_n == UNIT_OK);
	assign pv_hit = (cmd_n == posvel_q);
	assign fw_hit = !pv_hit && (cmd_n == fwver_q);

	assign status.emit_req = in_frame_q && is_end && sel_ok && (pv_hit || fw_hit);
	assign status.last_pos = (ptr_q == ((kind_q == KIND_FWVER) ? FW_LAST : PV_LAST));

	// entries not written since the last clear read as zero
	assign rd_byte = valid_q[ptr_q] ? store_q[ptr_q] : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			posvel_q   <= POSVEL_RST;
			fwver_q    <= FWVER_RST;
			hdr_cnt_q  <= 2'd0;
			in_frame_q <= 1'b0;
			idx_q      <= '0;
			valid_q    <= '0;
			cmd_q      <= 8'd0;
			sel_q      <= 8'd0;
			unit_q     <= 8'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POSVEL: posvel_q <= cfg_data;
					REG_FWVER:  fwver_q  <= cfg_data;
					default:    posvel_q <= posvel_q;
				endcase
			end
			if (cmd.take) begin
				cmd_q  <= cmd_n;
				sel_q  <= sel_n;
				unit_q <= unit_n;
				if (!in_frame_q && is_hdr) begin
					if (hdr_cnt_q == 2'd2) begin
						hdr_cnt_q  <= 2'd0;
						in_frame_q <= 1'b1;
					end else begin
						hdr_cnt_q <= hdr_cnt_q + 2'd1;
					end
				end
			end
			if (closing) begin
				in_frame_q <= 1'b0;
				idx_q      <= '0;
			end else if (put) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			// a replying frame keeps its store until the burst is done
			if ((closing && !status.emit_req) || cmd.finish)
				valid_q <= '0;
			else if (put && in_store)
				valid_q[idx_q[PTR_W-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (put && in_store)
			store_q[idx_q[PTR_W-1:0]] <= rx_byte;
		if (closing && status.emit_req) begin
			kind_q <= pv_hit ? KIND_POSVEL : KIND_FWVER;
			ptr_q  <= pv_hit ? PV_FIRST : FW_FIRST;
		end else if (cmd.load) begin
			ptr_q <= ptr_q + PTR_W'(1);
		end
		if (cmd.load) begin
			out_byte     <= rd_byte;
			payload_kind <= kind_q;
			last         <= status.last_pos;
		end
	end

endmodule

>>> rtl/mrfp_ctrl.sv
// ----------------------------------------------------------------------------
// mrfp_ctrl
// controller: input acceptance, payload burst sequencing, output valid
// ----------------------------------------------------------------------------
module mrfp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mrfp_pkg::dp_status_t status,
	output mrfp_pkg::ctrl_cmd_t  cmd
);
	import mrfp_pkg::*;

	localparam logic ST_RUN  = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign in_ready   = (state_q == ST_RUN);
	assign out_valid  = out_valid_q;
	assign out_free   = !out_valid_q || out_ready;
	assign cmd.take   = in_valid && in_ready;
	assign cmd.load   = (state_q == ST_EMIT) && out_free;
	assign cmd.finish = cmd.load && status.last_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (cmd.take && status.emit_req)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.finish)
						state_q <= ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/motor_reply_frame_parser.sv
// ----------------------------------------------------------------------------
// motor_reply_frame_parser
// parses reply frames from a motor controller link and emits payload bytes
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready, rx_byte): one received byte per
//   transaction. while no burst is running in_ready is high and a byte is
//   taken every cycle, so the input side runs at one byte per cycle.
//   output channel (out_valid/out_ready, out_byte, payload_kind, last): the
//   payload of a matching frame, twelve bytes for position/velocity or six
//   for firmware version, last high on the final byte.
//   first payload byte: it enters the output register after the closing 0x3B
//   transaction; further bytes follow one per cycle while out_ready is high.
//   input hold-off: the input is held off (in_ready low) from the closing byte
//   until the final payload byte has entered the output register, and stays
//   held off longer while the receiver stalls.
//   receiver stall: the output register holds its byte, the burst pauses and
//   input stays held off; the final byte can wait in the output register
//   while new input transactions are already taken.
//   reset (arst_n low): hunting for the header, frame store empty, field
//   latches zero, posvel_code 12, fwver_code 1.
//   configuration: cfg_we writes cfg_data to posvel_code (index 0) or
//   fwver_code (index 1); write only while no burst is in flight.
// ----------------------------------------------------------------------------
module motor_reply_frame_parser #(
	parameter int FRAME_MAX = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       payload_kind,
	output logic       last
);
	import mrfp_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// controller: decides when bytes are taken and when payload moves out
	mrfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: header counting, frame store, latches and output register
	mrfp_datapath #(
		.FRAME_MAX (FRAME_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_byte      (rx_byte),
		.cmd          (cmd),
		.status       (status),
		.out_byte     (out_byte),
		.payload_kind (payload_kind),
		.last         (last)
	);

endmodule

>>> rtl/mrfp_checker.sv
// ----------------------------------------------------------------------------
// mrfp_checker
// port-level checks of the motor reply frame parser
// ----------------------------------------------------------------------------
module mrfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       payload_kind,
	input logic       last
);
	import mrfp_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("output byte changed under stall");

	// input is held off while a burst still has bytes to come
	a_burst_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input taken during payload burst");

	// only the closing byte starts a burst
	a_close_only: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && rx_byte != END_BYTE |=> in_ready)
		else $error("burst started by non-closing byte");

	// a burst runs without gaps and keeps its kind
	a_kind_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=>
			out_valid && payload_kind == $past(payload_kind))
		else $error("payload burst broken or kind changed");

endmodule

bind motor_reply_frame_parser mrfp_checker u_chk (.*);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// motor reply frame parser testbench
// sends header, command and payload bytes into the parser and checks every
// payload byte that comes out against a cycle-free behavioural predictor;
// a short directed table comes first, then mostly well-formed random frames
// under several command code settings, with random gaps on both sides in
// all but one setting
module testbench;

	import mrfp_pkg::*;

	localparam int FRAME_MAX    = 64;
	localparam int DRAIN_CYCLES = 16;   // settle time once the payload queue is empty
	localparam int HOLD_CYCLES  = 150;  // long receiver hold-off
	localparam int END_LIMIT    = 5000; // bound on the final drain
	localparam int PHASE_ITEMS  = 40;   // random bytes per code setting, rounded up to whole frames

	// one expected payload byte
	typedef struct packed {
		logic [7:0] data;
		logic       kind;
		logic       last;
	} payload_t;

	// one row of the directed table; chk marks rows with a typed-in outcome
	typedef struct packed {
		logic [7:0] rx;
		logic       chk;
		logic [7:0] n_res;
		logic [7:0] first;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       payload_kind;
	logic       last;

	// predictor state, mirrors the parser
	logic [1:0] hdr_cnt;
	logic       framing;
	logic [6:0] wr_idx;
	logic [7:0] frame_bytes [STORE_DEPTH];
	logic [7:0] cmd_seen;
	logic [7:0] sel_seen;
	logic [7:0] unit_seen;
	logic [7:0] posvel_cfg;
	logic [7:0] fwver_cfg;
	logic       overflow_seen;
	logic [7:0] run_first;

	payload_t   payload_due_q [$];

	bit gaps_on;
	bit hold_req;
	int err_cnt;
	int bytes_sent;
	int payload_checked;
	int posvel_replies;
	int fwver_replies;
	int saturated_frames;
	int code_settings;

	// directed table, written against the reset codes
	dir_row_t dir_tbl [25] = '{
		'{8'h00,      1'b1, 8'd0,  8'h00},    // noise while hunting
		'{HDR_BYTE,   1'b0, 8'd0,  8'h00},    // first header byte
		'{8'hFF,      1'b1, 8'd0,  8'h00},    // ignored, count kept
		'{HDR_BYTE,   1'b0, 8'd0,  8'h00},
		'{END_BYTE,   1'b1, 8'd0,  8'h00},    // end byte outside a frame does nothing
		'{HDR_BYTE,   1'b0, 8'd0,  8'h00},    // third header byte opens the frame
		'{FWVER_RST,  1'b0, 8'd0,  8'h00},
		'{SEL_OK,     1'b0, 8'd0,  8'h00},
		'{UNIT_OK,    1'b0, 8'd0,  8'h00},
		'{END_BYTE,   1'b1, 8'd6,  END_BYTE}, // short firmware frame, end byte in the run
		'{HDR_BYTE,   1'b0, 8'd0,  8'h00},
		'{HDR_BYTE,   1'b0, 8'd0,  8'h00},
		'{HDR_BYTE,   1'b0, 8'd0,  8'h00},
		'{POSVEL_RST, 1'b0, 8'd0,  8'h00},
		'{SEL_OK,     1'b0, 8'd0,  8'h00},
		'{UNIT_OK,    1'b0, 8'd0,  8'h00},
		'{8'hFF,      1'b0, 8'd0,  8'h00},
		'{8'h80,      1'b0, 8'd0,  8'h00},
		'{8'h7F,      1'b0, 8'd0,  8'h00},
		'{END_BYTE,   1'b1, 8'd12, SEL_OK},   // position/velocity run starts at the select byte
		'{HDR_BYTE,   1'b0, 8'd0,  8'h00},
		'{HDR_BYTE,   1'b0, 8'd0,  8'h00},
		'{HDR_BYTE,   1'b0, 8'd0,  8'h00},
		'{END_BYTE,   1'b1, 8'd0,  8'h00},    // end byte lands on the command slot
		'{8'hFF,      1'b1, 8'd0,  8'h00}
	};

	motor_reply_frame_parser #(
		.FRAME_MAX(FRAME_MAX)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.payload_kind(payload_kind),
		.last        (last)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// hard stop if the run hangs
	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic flag(input string msg);
		err_cnt++;
		if (err_cnt <= 10) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	// store a byte at the write position, saturating at the frame limit
	task automatic store_byte(input logic [7:0] b);
		if (wr_idx < FRAME_MAX) begin
			if (wr_idx < STORE_DEPTH) begin
				frame_bytes[wr_idx[3:0]] = b;
			end
			wr_idx++;
		end else begin
			overflow_seen = 1'b1;
		end
	endtask

	// queue the stored bytes first..lastp as one payload run
	task automatic queue_payload_run(input int first, input int lastp, input logic kind,
			output int n);
		for (int p = first; p <= lastp; p++) begin
			payload_due_q.insert(payload_due_q.size(),
				payload_t'{frame_bytes[p], kind, p == lastp});
		end
		n = lastp - first + 1;
		run_first = frame_bytes[first];
		if (kind == KIND_POSVEL) begin
			posvel_replies++;
		end else begin
			fwver_replies++;
		end
	endtask

	// predictor: one received byte in, payload bytes queued, n = how many
	task automatic parse_reply_byte(input logic [7:0] b, output int n);
		logic ok;
		n = 0;
		if (!framing) begin
			// hunting: only header bytes are stored and counted
			if (b == HDR_BYTE) begin
				store_byte(b);
				hdr_cnt = hdr_cnt + 2'd1;
				if (hdr_cnt == 2'd3) begin
					hdr_cnt = 2'd0;
					framing = 1'b1;
				end
			end
		end else begin
			if (wr_idx == POS_CMD) cmd_seen = b;
			if (wr_idx == POS_SEL) sel_seen = b;
			if (wr_idx == POS_UNIT) unit_seen = b;
			store_byte(b);
			if (b == END_BYTE) begin
				ok = (sel_seen == SEL_OK) && (unit_seen == UNIT_OK);
				// position/velocity wins when both codes match; no fallback
				if (cmd_seen == posvel_cfg) begin
					if (ok) queue_payload_run(int'(PV_FIRST), int'(PV_LAST), KIND_POSVEL, n);
				end else if (cmd_seen == fwver_cfg) begin
					if (ok) queue_payload_run(int'(FW_FIRST), int'(FW_LAST), KIND_FWVER, n);
				end
				if (overflow_seen) saturated_frames++;
				overflow_seen = 1'b0;
				wr_idx = '0;
				framing = 1'b0;
				for (int i = 0; i < STORE_DEPTH; i++) frame_bytes[i] = 8'h00;
			end
		end
	endtask

	// one input transaction; called and returns at a falling edge
	task automatic send_rx(input logic [7:0] b, output int n);
		while (gaps_on && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		parse_reply_byte(b, n);
		bytes_sent++;
		@(negedge clk);
	endtask

	// write both command codes once the parser has gone quiet
	task automatic write_codes(input logic [7:0] pv, input logic [7:0] fw);
		in_valid <= 1'b0;
		while (payload_due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_POSVEL;
		cfg_data  <= pv;
		@(negedge clk);
		cfg_index <= REG_FWVER;
		cfg_data  <= fw;
		@(negedge clk);
		cfg_we <= 1'b0;
		posvel_cfg = pv;
		fwver_cfg  = fw;
		code_settings++;
	endtask

	// one frame; well forces a clean matching position/velocity frame
	task automatic send_frame(input bit well);
		int         n;
		int         mode;
		int         len;
		int         r;
		logic [7:0] b;
		mode = well ? 9 : $urandom_range(0, 19);
		// leading noise, mostly non-header bytes
		if (!well) begin
			repeat ($urandom_range(0, 3)) begin
				b = 8'($urandom);
				if (b == HDR_BYTE && $urandom_range(0, 3) != 0) b = ~b;
				send_rx(b, n);
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (!well && $urandom_range(0, 9) == 0) send_rx(8'h55, n);
			send_rx(HDR_BYTE, n);
		end
		r = $urandom_range(0, 9);
		if (well || r < 4) begin
			b = posvel_cfg;
		end else if (r < 7) begin
			b = fwver_cfg;
		end else begin
			b = 8'($urandom);
		end
		send_rx(b, n);
		// mode 0 closes after the command, mode 1 after the select
		if (mode >= 1) begin
			b = (well || $urandom_range(0, 4) != 0) ? SEL_OK : 8'($urandom);
			send_rx(b, n);
			if (mode >= 2) begin
				b = (well || $urandom_range(0, 4) != 0) ? UNIT_OK : 8'($urandom);
				send_rx(b, n);
				// modes 2 and 3 may run past the frame limit
				len = (mode == 2 || mode == 3) ? $urandom_range(56, 70) : $urandom_range(0, 12);
				repeat (len) begin
					b = 8'($urandom);
					if (b == END_BYTE && (well || $urandom_range(0, 3) != 0)) b = b + 8'd1;
					send_rx(b, n);
				end
			end
		end
		// mode 4 leaves the frame open, the next header bytes become payload
		if (mode != 4) send_rx(END_BYTE, n);
	endtask

	task automatic run_random(input int count);
		int stop;
		stop = bytes_sent + count;
		while (bytes_sent < stop) send_frame(1'b0);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= !(gaps_on && $urandom_range(0, 99) < 34);
			end
		end
	end

	// payload checker: every output transaction against the oldest expectation
	always @(posedge clk) begin
		payload_t exp_b;
		if (arst_n && out_valid && out_ready) begin
			if (payload_due_q.size() == 0) begin
				flag($sformatf("unexpected payload byte %02h kind %0b last %0b",
					out_byte, payload_kind, last));
			end else begin
				exp_b = payload_due_q.pop_front();
				payload_checked++;
				if (out_byte !== exp_b.data || payload_kind !== exp_b.kind ||
						last !== exp_b.last) begin
					flag($sformatf("payload byte %02h/%0b/%0b, expected %02h/%0b/%0b",
						out_byte, payload_kind, last, exp_b.data, exp_b.kind, exp_b.last));
				end
			end
		end
	end

	// main sequence
	initial begin
		int w;
		int n;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_POSVEL;
		cfg_data  = 8'h00;
		in_valid  = 1'b0;
		rx_byte   = 8'h00;
		gaps_on   = 1'b1;
		hold_req  = 1'b0;

		// predictor reset state
		hdr_cnt       = 2'd0;
		framing       = 1'b0;
		wr_idx        = '0;
		cmd_seen      = 8'h00;
		sel_seen      = 8'h00;
		unit_seen     = 8'h00;
		posvel_cfg    = POSVEL_RST;
		fwver_cfg     = FWVER_RST;
		overflow_seen = 1'b0;
		run_first     = 8'h00;
		for (int i = 0; i < STORE_DEPTH; i++) frame_bytes[i] = 8'h00;
		code_settings = 1;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table with the reset codes
		foreach (dir_tbl[i]) begin
			send_rx(dir_tbl[i].rx, n);
			if (dir_tbl[i].chk && (n != int'(dir_tbl[i].n_res) ||
					(n > 0 && run_first != dir_tbl[i].first))) begin
				flag($sformatf("table row %0d gives %0d bytes from %02h, expected %0d from %02h",
					i, n, run_first, dir_tbl[i].n_res, dir_tbl[i].first));
			end
		end

		// lowest and highest codes; long hold-off so the input backs up
		write_codes(8'h00, 8'hFF);
		hold_req = 1'b1;
		send_frame(1'b1);
		run_random(PHASE_ITEMS);

		write_codes(8'hFF, 8'h00);
		run_random(PHASE_ITEMS);

		// both codes equal to the end byte: a frame closing on the command slot
		// replies from the select and unit left over from before
		write_codes(END_BYTE, END_BYTE);
		run_random(PHASE_ITEMS);

		// no gaps on either side
		gaps_on = 1'b0;
		write_codes(8'($urandom), 8'($urandom));
		run_random(PHASE_ITEMS);
		gaps_on = 1'b1;

		write_codes(POSVEL_RST, FWVER_RST);
		run_random(PHASE_ITEMS);

		// drain the remaining payload
		in_valid <= 1'b0;
		for (w = 0; w < END_LIMIT && payload_due_q.size() != 0; w++) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (payload_due_q.size() != 0) begin
			flag($sformatf("%0d payload bytes never arrived", payload_due_q.size()));
		end

		$display("%0d bytes sent over %0d code settings, %0d payload bytes checked",
			bytes_sent, code_settings, payload_checked);
		$display("%0d position/velocity and %0d firmware replies, %0d frames past the limit",
			posvel_replies, fwver_replies, saturated_frames);
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> motor_reply_frame_parser.f
rtl/mrfp_pkg.sv
rtl/mrfp_datapath.sv
rtl/mrfp_ctrl.sv
rtl/motor_reply_frame_parser.sv
rtl/mrfp_checker.sv
dv/testbench.sv
